@@ design/pcqc_pkg.sv @@
// Shared types and constants for the per-channel quartic calibration unit.
package pcqc_pkg;

  // Number formats and store geometry
  localparam int CHANNELS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 48;
  localparam int TERMS       = 5;
  localparam int STEPS       = TERMS - 1;
  localparam int CH_BITS     = 6;
  localparam int IDX_BITS    = 3;
  localparam int PROD_BITS   = COEFF_BITS + SAMPLE_BITS + 1;

  // Rows actually addressable through the channel field
  localparam int MEM_ROWS  = (CHANNELS < (2 ** CH_BITS)) ? CHANNELS : (2 ** CH_BITS);
  localparam int ROW_BITS  = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
  localparam int TERM_BITS = (TERMS > 1) ? $clog2(TERMS) : 1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_CALIB = 1'b1
  } op_e;

  typedef logic signed [COEFF_BITS-1:0] coeff_t;
  typedef coeff_t [TERMS-1:0] coeff_row_t;

  // Input transfer
  typedef struct packed {
    op_e                    opcode;
    logic [CH_BITS-1:0]     channel;
    logic [IDX_BITS-1:0]    coeff_index;
    coeff_t                 coeff_value;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  // Output transfer
  typedef struct packed {
    coeff_t             energy;
    logic               saturated;
    logic [CH_BITS-1:0] channel_out;
  } out_item_t;

  // Coefficient store write port
  typedef struct packed {
    logic                 en;
    logic [ROW_BITS-1:0]  row;
    logic [TERM_BITS-1:0] term;
    coeff_t               data;
  } mem_wr_t;

  // Payload between Horner steps; pend[0] is the next coefficient to add
  typedef struct packed {
    coeff_t                 acc;
    coeff_t [STEPS-1:0]     pend;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CH_BITS-1:0]     channel;
    logic                   sat;
  } pipe_t;

  // Stage handshake towards a Horner step
  typedef struct packed {
    logic  valid;
    pipe_t data;
  } pipe_hs_t;

endpackage

@@ design/pcqc_coeff_mem.sv @@
// Coefficient store: one row of all terms per channel, term-wise write, registered row read.
module pcqc_coeff_mem (
  input  logic                  clk_i,
  input  pcqc_pkg::mem_wr_t     wr_i,
  input  logic                  rd_en_i,
  input  logic [pcqc_pkg::ROW_BITS-1:0] rd_row_i,
  output pcqc_pkg::coeff_row_t  rd_data_o
);

  pcqc_pkg::coeff_row_t mem_q [pcqc_pkg::MEM_ROWS];
  pcqc_pkg::coeff_row_t rd_q;

  // Single-term write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.row][wr_i.term] <= wr_i.data;
    end
  end

  // Whole-row read, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ design/pcqc_horner_step.sv @@
// One Horner step: registered multiply by the sample, then floor shift, add and clamp.
module pcqc_horner_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcqc_pkg::pipe_hs_t up_i,
  output logic               up_en_o,
  output pcqc_pkg::pipe_hs_t dn_o,
  input  logic               dn_en_i
);

  typedef struct packed {
    logic signed [pcqc_pkg::PROD_BITS-1:0] prod;
    pcqc_pkg::pipe_t                       rest;
  } mul_t;

  logic  m_v_q, a_v_q;
  mul_t  m_q, m_d;
  pcqc_pkg::pipe_t a_q, a_d;
  logic  m_en, a_en;

  // Stage enables: a stage loads when empty or when its content moves on
  assign a_en    = !a_v_q || dn_en_i;
  assign m_en    = !m_v_q || a_en;
  assign up_en_o = m_en;

  // Multiply stage
  always_comb begin
    logic signed [pcqc_pkg::PROD_BITS-1:0] acc_ext;
    logic signed [pcqc_pkg::PROD_BITS-1:0] x_ext;
    acc_ext   = pcqc_pkg::PROD_BITS'(up_i.data.acc);
    x_ext     = pcqc_pkg::PROD_BITS'({1'b0, up_i.data.sample});
    m_d.prod  = acc_ext * x_ext;
    m_d.rest  = up_i.data;
  end

  // Add stage: floor shift, add next coefficient, saturate
  always_comb begin
    logic signed [pcqc_pkg::PROD_BITS-1:0]  shifted;
    logic signed [pcqc_pkg::COEFF_BITS:0]   sum;
    shifted = m_q.prod >>> pcqc_pkg::SAMPLE_BITS;
    sum     = (pcqc_pkg::COEFF_BITS+1)'($signed(shifted[pcqc_pkg::COEFF_BITS-1:0]))
            + (pcqc_pkg::COEFF_BITS+1)'($signed(m_q.rest.pend[0]));
    a_d     = m_q.rest;
    if (sum[pcqc_pkg::COEFF_BITS] != sum[pcqc_pkg::COEFF_BITS-1]) begin
      a_d.sat = 1'b1;
      a_d.acc = sum[pcqc_pkg::COEFF_BITS]
              ? {1'b1, {(pcqc_pkg::COEFF_BITS-1){1'b0}}}
              : {1'b0, {(pcqc_pkg::COEFF_BITS-1){1'b1}}};
    end else begin
      a_d.acc = sum[pcqc_pkg::COEFF_BITS-1:0];
    end
    // shift the pending coefficients down one place
    for (int j = 0; j < pcqc_pkg::STEPS - 1; j++) begin
      a_d.pend[j] = m_q.rest.pend[j+1];
    end
    a_d.pend[pcqc_pkg::STEPS-1] = '0;
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
    end else begin
      if (m_en) m_v_q <= up_i.valid;
      if (a_en) a_v_q <= m_v_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (m_en && up_i.valid) m_q <= m_d;
    if (a_en && m_v_q)      a_q <= a_d;
  end

  assign dn_o.valid = a_v_q;
  assign dn_o.data  = a_q;

endmodule

@@ design/per_channel_quartic_calibration_unit.sv @@
// Top level of the per-channel quartic calibration unit.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries two kinds of
// transfer. A load writes one coefficient of one channel into the store at
// the edge it is taken; it gives no result. A calibrate reads the channel's
// coefficient row and evaluates the quartic by Horner's rule in the sample.
// Output channel (out_valid_o / out_stall_i / out_item_o) carries one result
// per calibrate, in order of acceptance.
// Throughput is one transfer per cycle while the input is not stalled; loads
// and calibrates may be mixed freely and a calibrate sees every load taken before it.
// A calibrate passes through the store read and the sample register at the
// accepting edge, then the multiply and the shift/add/clamp registers of each
// of the four Horner steps, and last the output register.
// While the receiver stalls, the result holds in the output register and the
// stages behind it keep filling; input stalls only once no stage is free.
// Reset clears all valid flags; the coefficient store is not cleared and must
// be loaded for a channel before that channel is calibrated.
module per_channel_quartic_calibration_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcqc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcqc_pkg::out_item_t out_item_o
);

  logic                 accept;
  logic                 ch_ok;
  pcqc_pkg::mem_wr_t    wr;
  pcqc_pkg::coeff_row_t row;

  logic                             s1_v_q;
  logic                             s1_ok_q;
  logic [pcqc_pkg::SAMPLE_BITS-1:0] s1_sample_q;
  logic [pcqc_pkg::CH_BITS-1:0]     s1_channel_q;
  logic                             s1_en;

  pcqc_pkg::pipe_hs_t  pipe  [pcqc_pkg::STEPS+1];
  logic                en    [pcqc_pkg::STEPS+1];

  logic                out_v_q;
  pcqc_pkg::out_item_t out_q;
  logic                out_en;

  // Handshake and item decode
  assign s1_en      = !s1_v_q || en[0];
  assign in_stall_o = !s1_en;
  assign accept     = in_valid_i && s1_en;
  assign ch_ok      = int'(in_item_i.channel) < pcqc_pkg::CHANNELS;

  // Load path: write at the accepting edge
  always_comb begin
    wr.en   = accept && (in_item_i.opcode == pcqc_pkg::OP_LOAD) && ch_ok
           && (in_item_i.coeff_index < pcqc_pkg::IDX_BITS'(pcqc_pkg::TERMS));
    wr.row  = in_item_i.channel[pcqc_pkg::ROW_BITS-1:0];
    wr.term = in_item_i.coeff_index[pcqc_pkg::TERM_BITS-1:0];
    wr.data = in_item_i.coeff_value;
  end

  pcqc_coeff_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept && (in_item_i.opcode == pcqc_pkg::OP_CALIB)),
    .rd_row_i  (in_item_i.channel[pcqc_pkg::ROW_BITS-1:0]),
    .rd_data_o (row)
  );

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= accept && (in_item_i.opcode == pcqc_pkg::OP_CALIB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_item_i.opcode == pcqc_pkg::OP_CALIB)) begin
      s1_ok_q      <= ch_ok;
      s1_sample_q  <= in_item_i.sample;
      s1_channel_q <= in_item_i.channel;
    end
  end

  // Seed the Horner chain: top coefficient as accumulator, rest pending
  always_comb begin
    pipe[0].valid        = s1_v_q;
    pipe[0].data.acc     = s1_ok_q ? row[pcqc_pkg::TERMS-1] : '0;
    for (int j = 0; j < pcqc_pkg::STEPS; j++) begin
      pipe[0].data.pend[j] = s1_ok_q ? row[pcqc_pkg::TERMS-2-j] : '0;
    end
    pipe[0].data.sample  = s1_sample_q;
    pipe[0].data.channel = s1_channel_q;
    pipe[0].data.sat     = 1'b0;
  end

  // Horner steps
  for (genvar k = 0; k < pcqc_pkg::STEPS; k++) begin : g_step
    pcqc_horner_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .up_i    (pipe[k]),
      .up_en_o (en[k]),
      .dn_o    (pipe[k+1]),
      .dn_en_i (en[k+1])
    );
  end

  // Output register
  assign out_en                 = !out_v_q || !out_stall_i;
  assign en[pcqc_pkg::STEPS]    = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= pipe[pcqc_pkg::STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && pipe[pcqc_pkg::STEPS].valid) begin
      out_q.energy      <= pipe[pcqc_pkg::STEPS].data.acc;
      out_q.saturated   <= pipe[pcqc_pkg::STEPS].data.sat;
      out_q.channel_out <= pipe[pcqc_pkg::STEPS].data.channel;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule
